>>> hw/rtl/slt_pkg.sv
// slt_pkg: shared types and codes for the sorted list table.
// Used by slt_cell and sorted_list_table_unit. No dependencies.
`timescale 1ns / 1ps

package slt_pkg;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam int COUNT_W = 5;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } slt_item_t;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] count;
        logic               empty_res;
        logic [1:0]         status;
    } slt_result_t;

    // Broadcast write enables from the top level to every cell
    typedef struct packed {
        logic insert_en;
        logic delete_en;
    } slt_ctl_t;

    // Per-cell compare flags
    typedef struct packed {
        logic occ;   // cell holds a stored value
        logic gt;    // occupied and stored value > key
        logic ge;    // occupied and stored value >= key
        logic hit;   // occupied and stored value == key
    } slt_flags_t;

endpackage

>>> hw/rtl/sorted_list_table_unit.sv
// sorted_list_table_unit: a sorted table of up to DEPTH signed values built
// as a row of compare-and-shift cells. Depends on slt_pkg and slt_cell.
// The result strobe (done) rises in the cycle after start is taken.
// Throughput: one item per cycle; every cell compares and shifts at once.
// busy stays low: the receiver cannot stall and no item needs more time.
// Reset clears the fill count and the result strobe; slot values are not reset.
`timescale 1ns / 1ps

module sorted_list_table_unit import slt_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  slt_item_t   item,
    output logic        done,
    output slt_result_t result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               done_reg;
    slt_result_t        result_reg;
    slt_result_t        result_next;

    slt_ctl_t           ctl;
    logic signed [31:0] cell_val [DEPTH];
    slt_flags_t         cell_flags [DEPTH];
    logic [DEPTH-1:0]   hit_vec;
    logic               any_hit;
    logic               is_full;
    logic [CW+COUNT_W-1:0] count_wide;

    // The table never holds an item off.
    assign busy = 1'b0;

    assign is_full = (count_reg >= FULL_COUNT);

    // Insert only with a free slot; delete only when a stored value matches.
    always_comb
    begin
        ctl.insert_en = start && (item.cmd == CMD_INSERT) && !is_full;
        ctl.delete_en = start && (item.cmd == CMD_DELETE) && any_hit;
    end

    // Row of cells: each sees its left neighbor's value and gt flag, and
    // its right neighbor's value. The ends see zero.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [31:0] lv;
        logic               lgt;
        logic signed [31:0] rv;

        if (i == 0)
        begin : g_first
            assign lv  = '0;
            assign lgt = 1'b0;
        end
        else
        begin : g_mid
            assign lv  = cell_val[i-1];
            assign lgt = cell_flags[i-1].gt;
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign rv = '0;
        end
        else
        begin : g_inner
            assign rv = cell_val[i+1];
        end

        slt_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk       (clk),
            .count     (count_reg),
            .key       (item.value),
            .ctl       (ctl),
            .left_val  (lv),
            .left_gt   (lgt),
            .right_val (rv),
            .val       (cell_val[i]),
            .flags     (cell_flags[i])
        );

        assign hit_vec[i] = cell_flags[i].hit;
    end

    assign any_hit = |hit_vec;

    // Advance the fill count.
    always_comb
    begin
        count_next = count_reg;
        if (start)
        begin
            case (item.cmd)
                CMD_INSERT: if (ctl.insert_en) count_next = count_reg + CW'(1);
                CMD_DELETE: if (ctl.delete_en) count_next = count_reg - CW'(1);
                CMD_LOOKUP: count_next = count_reg;
                CMD_CLEAR:  count_next = '0;
                default:    count_next = count_reg;
            endcase
        end
    end

    // Count is reported in five bits, zero-extended or masked as needed.
    assign count_wide = {{COUNT_W{1'b0}}, count_next};

    always_comb
    begin
        result_next.found     = 1'b0;
        result_next.status    = ST_OK;
        result_next.count     = count_wide[COUNT_W-1:0];
        result_next.empty_res = (count_next == '0);
        case (item.cmd)
            CMD_INSERT:
            begin
                if (is_full)
                    result_next.status = ST_FULL;
            end
            CMD_DELETE:
            begin
                result_next.found = any_hit;
                if (!any_hit)
                    result_next.status = ST_ABSENT;
            end
            CMD_LOOKUP: result_next.found = any_hit;
            CMD_CLEAR:  result_next.found = 1'b0;
            default:    result_next.found = 1'b0;
        endcase
    end

    // Control state: fill count and strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    // Hold the result payload for its strobe cycle.
    always_ff @(posedge clk)
    begin
        if (start)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> hw/rtl/slt_cell.sv
// slt_cell: one slot of the sorted table; compares its value with the key
// and shifts left or right with its neighbors. Depends on slt_pkg.
`timescale 1ns / 1ps

module slt_cell import slt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
)
(
    input  logic               clk,
    input  logic [CW-1:0]      count,
    input  logic signed [31:0] key,
    input  slt_ctl_t           ctl,
    input  logic signed [31:0] left_val,
    input  logic               left_gt,
    input  logic signed [31:0] right_val,
    output logic signed [31:0] val,
    output slt_flags_t         flags
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic signed [31:0] val_reg;
    logic signed [31:0] val_next;
    logic               at_count;

    assign val = val_reg;
    assign at_count = (count == MY_IDX);

    always_comb
    begin
        flags.occ = (MY_IDX < count);
        flags.gt  = flags.occ && (val_reg > key);
        flags.ge  = flags.occ && (val_reg >= key);
        flags.hit = flags.occ && (val_reg == key);
    end

    // Insert: take left neighbor when the gap opens to our left, else the key if ours is greater or we are at count.
    // Delete: pull from the right from the matching slot upward.
    always_comb
    begin
        val_next = val_reg;
        if (ctl.insert_en)
        begin
            if (left_gt)
                val_next = left_val;
            else if (flags.gt || at_count)
                val_next = key;
        end
        else if (ctl.delete_en && flags.ge)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule
